### rtl/hol_pkg.sv
// Shared types, constants and helpers for the hex object line loader.
package hol_pkg;

	localparam int MEM_SIZE       = 4096;
	localparam int MAX_LINE_BYTES = 10;

	localparam int CNT_W  = $clog2(MAX_LINE_BYTES + 1);
	localparam int BUF_AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int COL_W  = 5;

	localparam logic [COL_W-1:0] BAR_COL   = 5'd28;
	localparam logic [COL_W-1:0] DIGIT_COL = 5'd7;
	localparam logic [COL_W-1:0] COL_SAT   = 5'd29;

	localparam logic [7:0] CHAR_BAR   = 8'h7C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
	localparam logic [1:0] KIND_EOF    = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
	} hol_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [15:0] line_number;
		logic        loaded;
		logic        last;
	} hol_out_t;

	typedef struct packed {
		logic runend;
		logic posbad;
		logic cmtbad;
		logic bar;
		logic blank7;
		logic blank0;
		logic x1;
		logic zero0;
	} hol_flags_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_BYTES,
		SEQ_STATUS,
		SEQ_EOF
	} seq_state_t;

	// Returns {valid, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

### rtl/hex_object_line_loader_core.sv
// Throughput: one character word per cycle inside a line.
// A word that ends a line (newline, or end of file) blocks further input until all its
// results are out: the sequencer drains the line buffer RAM one byte per cycle, while the
// output is not stalled, into the single output register, behind the sequencer state register.
// Reset (arst_n low) clears all control state and sets the line counter to one;
// the line buffer RAM is not cleared, its entries are read only after being written.
module hex_object_line_loader_core
	import hol_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_ready,
	input  hol_in_t  src_word,
	output logic     res_valid,
	input  logic     res_ready,
	output hol_out_t res_word
);

	// line parse state
	logic [COL_W-1:0] column_q;
	hol_flags_t       flags_q;
	logic             line_bad_q;
	logic [COL_W-1:0] run_end_q;
	logic [11:0]      line_addr_q;
	logic [3:0]       high_nib_q;
	logic [CNT_W-1:0] byte_cnt_q;

	// file state
	logic [12:0] prev_last_q;
	logic [15:0] line_cnt_q;
	logic        any_acc_q;
	logic        halted_q;

	// result job
	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] job_count_q;
	logic [11:0]      job_addr_q;
	logic [15:0]      job_line_q;
	logic             job_ok_q;
	logic             job_eof_q;
	logic             job_loaded_q;
	logic [BUF_AW-1:0] idx_q, idx_d;

	// output register
	logic     res_valid_q;
	hol_out_t res_word_q;
	hol_out_t out_d;
	logic     push;

	logic       accept, is_char, is_lf, blank, do_take, do_clear, do_end;
	logic [4:0] hexv;

	logic [COL_W-1:0] col_t, run_end_t;
	hol_flags_t       flags_t;
	logic             bad_t;
	logic [11:0]      addr_t;
	logic [3:0]       nib_t;
	logic [CNT_W-1:0] cnt_t;
	logic             buf_we;
	logic [7:0]       buf_rdata;

	logic        full, addr_only, comment, data_br, ok0, addr_lt, ok_data, line_ok, prev_upd;
	logic [12:0] prev_new;
	logic        eof_loaded;

	assign accept   = src_valid & src_ready;
	assign is_char  = (src_word.cmd == CMD_CHAR);
	assign is_lf    = (src_word.ch == CHAR_LF);
	assign blank    = (src_word.ch == CHAR_SPACE);
	assign hexv     = hex_digit(src_word.ch);
	assign do_take  = accept & is_char & ~halted_q & ~is_lf;
	assign do_end   = accept & ~halted_q & (is_char ? is_lf : (column_q != '0));
	assign do_clear = accept & (~is_char | (~halted_q & is_lf));

	// one character of the line
	always_comb begin
		col_t     = column_q;
		flags_t   = flags_q;
		bad_t     = line_bad_q;
		run_end_t = run_end_q;
		addr_t    = line_addr_q;
		nib_t     = high_nib_q;
		cnt_t     = byte_cnt_q;
		buf_we    = 1'b0;
		if (column_q < COL_SAT) begin
			col_t = column_q + 5'd1;
			if (column_q == BAR_COL) begin
				if (src_word.ch == CHAR_BAR) flags_t.bar = 1'b1;
			end else begin
				if (!blank) flags_t.cmtbad = 1'b1;
				if (column_q == 5'd0) begin
					if (src_word.ch == CHAR_ZERO) flags_t.zero0 = 1'b1;
					if (blank) flags_t.blank0 = 1'b1;
				end else if (column_q == 5'd1) begin
					if (src_word.ch == CHAR_X) flags_t.x1 = 1'b1;
					else bad_t = 1'b1;
				end else if (column_q <= 5'd4) begin
					if (!hexv[4]) bad_t = 1'b1;
					else addr_t = {line_addr_q[7:0], hexv[3:0]};
				end else if (column_q == 5'd5) begin
					if (src_word.ch != CHAR_COLON) bad_t = 1'b1;
				end else if (column_q == 5'd6) begin
					if (!blank) bad_t = 1'b1;
				end else begin
					if (!blank) flags_t.posbad = 1'b1;
					if (column_q == DIGIT_COL && blank) flags_t.blank7 = 1'b1;
					if (flags_q.runend) begin
						if (!blank) bad_t = 1'b1;
					end else if (blank) begin
						flags_t.runend = 1'b1;
						run_end_t      = column_q;
					end else if (!hexv[4]) begin
						bad_t = 1'b1;
					end else if (column_q[0]) begin
						// high digit sits on odd columns
						nib_t = hexv[3:0];
					end else if (byte_cnt_q < CNT_W'(MAX_LINE_BYTES)) begin
						buf_we = do_take;
						cnt_t  = byte_cnt_q + CNT_W'(1);
					end else begin
						bad_t = 1'b1;
					end
				end
			end
		end
	end

	// line verdict
	always_comb begin
		full      = (column_q >= BAR_COL);
		addr_only = flags_q.zero0 & flags_q.x1 & flags_q.blank7;
		comment   = flags_q.blank0;
		data_br   = flags_q.zero0 & ~flags_q.blank7;
		ok0       = ~line_bad_q & flags_q.runend & run_end_q[0] & (run_end_q > DIGIT_COL) &
			full & flags_q.bar;
		addr_lt   = ({1'b0, line_addr_q} < prev_last_q);
		prev_new  = {1'b0, line_addr_q} + 13'(byte_cnt_q) - 13'd1;
		ok_data   = ok0 & ~addr_lt & (prev_new < 13'(MEM_SIZE));
		prev_upd  = 1'b0;
		if (addr_only) begin
			line_ok = full & ~flags_q.posbad;
		end else if (comment) begin
			line_ok = full & ~flags_q.cmtbad & flags_q.bar;
		end else if (data_br) begin
			line_ok  = ok_data;
			prev_upd = ok0 & ~addr_lt;
		end else begin
			line_ok = 1'b0;
		end
		eof_loaded = (any_acc_q | (do_end & line_ok)) & ~(halted_q | (do_end & ~line_ok));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			flags_q     <= '0;
			line_bad_q  <= 1'b0;
			run_end_q   <= '0;
			line_addr_q <= '0;
			high_nib_q  <= '0;
			byte_cnt_q  <= '0;
			prev_last_q <= '0;
			line_cnt_q  <= 16'd1;
			any_acc_q   <= 1'b0;
			halted_q    <= 1'b0;
		end else begin
			if (do_take) begin
				column_q    <= col_t;
				flags_q     <= flags_t;
				line_bad_q  <= bad_t;
				run_end_q   <= run_end_t;
				line_addr_q <= addr_t;
				high_nib_q  <= nib_t;
				byte_cnt_q  <= cnt_t;
			end else if (do_clear) begin
				column_q    <= '0;
				flags_q     <= '0;
				line_bad_q  <= 1'b0;
				run_end_q   <= '0;
				line_addr_q <= '0;
				high_nib_q  <= '0;
				byte_cnt_q  <= '0;
			end
			if (do_end) begin
				if (prev_upd) prev_last_q <= prev_new;
				if (line_ok) begin
					any_acc_q <= 1'b1;
					if (line_cnt_q != 16'hFFFF) line_cnt_q <= line_cnt_q + 16'd1;
				end else begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	// latch the job for the sequencer on any word that makes results
	always_ff @(posedge clk) begin
		if (accept && (do_end || !is_char)) begin
			job_count_q  <= (line_ok && data_br) ? byte_cnt_q : '0;
			job_addr_q   <= line_addr_q;
			job_line_q   <= line_cnt_q;
			job_ok_q     <= line_ok;
			job_eof_q    <= ~is_char;
			job_loaded_q <= eof_loaded;
		end
	end

	hol_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LINE_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (buf_we),
		.waddr(byte_cnt_q[BUF_AW-1:0]),
		.wdata({high_nib_q, hexv[3:0]}),
		.raddr(idx_d),
		.rdata(buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// result sequencer; read address runs one step ahead so buf_rdata matches idx_q
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		push    = (state_q != SEQ_IDLE) && (!res_valid_q || res_ready);
		out_d   = '0;
		case (state_q)
			SEQ_IDLE: begin
				idx_d = '0;
				if (do_end) begin
					state_d = (line_ok && data_br && byte_cnt_q != '0) ? SEQ_BYTES : SEQ_STATUS;
				end else if (accept && !is_char) begin
					state_d = SEQ_EOF;
				end
			end
			SEQ_BYTES: begin
				out_d.kind        = KIND_BYTE;
				out_d.addr        = job_addr_q + 12'(idx_q);
				out_d.data        = buf_rdata;
				out_d.line_number = job_line_q;
				if (push) begin
					if ((CNT_W'(idx_q) + CNT_W'(1)) == job_count_q) begin
						idx_d   = '0;
						state_d = SEQ_STATUS;
					end else begin
						idx_d = idx_q + BUF_AW'(1);
					end
				end
			end
			SEQ_STATUS: begin
				out_d.kind        = job_ok_q ? KIND_ACCEPT : KIND_REJECT;
				out_d.line_number = job_line_q;
				out_d.last        = ~job_eof_q;
				if (push) state_d = job_eof_q ? SEQ_EOF : SEQ_IDLE;
			end
			SEQ_EOF: begin
				out_d.kind   = KIND_EOF;
				out_d.loaded = job_loaded_q;
				out_d.last   = 1'b1;
				if (push) state_d = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) res_word_q <= out_d;
	end

	assign src_ready = (state_q == SEQ_IDLE);
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

### rtl/hol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/hol_chk.sv
// Port-level assertions for the hex object line loader, bound to the top level.
module hol_chk
	import hol_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     res_valid,
	input logic     res_ready,
	input hol_out_t res_word
);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind == KIND_EOF |-> res_word.last && res_word.line_number == 16'd0)
		else $error("end-of-file status not final or carries a line number");

	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind == KIND_BYTE |-> !res_word.last && !res_word.loaded)
		else $error("byte write marked final or loaded");

	a_loaded_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.loaded |-> res_word.kind == KIND_EOF)
		else $error("loaded flag outside end-of-file status");

	a_line_number: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.kind == KIND_ACCEPT || res_word.kind == KIND_REJECT)
		|-> res_word.line_number != 16'd0 && res_word.addr == 12'd0)
		else $error("line status with zero line number or address");

endmodule

bind hex_object_line_loader_core hol_chk u_hol_chk (.*);

### sim/hex_object_line_loader_core_tb.sv
// Self-checking testbench for the hex object line loader core.
`timescale 1ns / 1ps

module hex_object_line_loader_core_tb
	import hol_pkg::*;
;

	localparam int CYCLE_LIMIT = 400000;

	// Line checker and loader predictor; holds the results still due from the core.
	class load_checker;
		hol_out_t   due_results[$];
		int         errors;
		int         col;
		hol_flags_t fl;
		bit         bad;
		int         run_end;
		logic [11:0] line_addr;
		logic [3:0] hi;
		logic [7:0] held[MAX_LINE_BYTES];
		int         nbytes;
		int         prev_last;
		logic [15:0] line_no;
		bit         any_ok;
		bit         halted;

		function new();
			clear_line();
			foreach (held[i]) held[i] = 8'h00;
			prev_last = 0;
			line_no = 16'd1;
			any_ok = 1'b0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function void clear_line();
			col = 0;
			fl = '0;
			bad = 1'b0;
			run_end = 0;
			line_addr = '0;
			hi = '0;
			nbytes = 0;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
			if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
			if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
			return -1;
		endfunction

		function void add(logic [1:0] kind, int addr, logic [7:0] data, logic [15:0] line,
				logic loaded);
			hol_out_t r;
			r.kind = kind;
			r.addr = 12'(addr);
			r.data = data;
			r.line_number = line;
			r.loaded = loaded;
			r.last = 1'b0;
			due_results.push_back(r);
		endfunction

		function void take_char(logic [7:0] c);
			int v;
			bit blank;
			int c0;
			v = nibble_of(c);
			blank = (c == CHAR_SPACE);
			c0 = col;
			if (c0 >= int'(COL_SAT)) return;
			col = c0 + 1;
			if (c0 == int'(BAR_COL)) begin
				if (c == CHAR_BAR) fl.bar = 1'b1;
				return;
			end
			if (!blank) fl.cmtbad = 1'b1;
			if (c0 == 0) begin
				if (c == CHAR_ZERO) fl.zero0 = 1'b1;
				if (blank) fl.blank0 = 1'b1;
			end else if (c0 == 1) begin
				if (c == CHAR_X) fl.x1 = 1'b1;
				else bad = 1'b1;
			end else if (c0 <= 4) begin
				if (v < 0) bad = 1'b1;
				else line_addr = {line_addr[7:0], v[3:0]};
			end else if (c0 == 5) begin
				if (c != CHAR_COLON) bad = 1'b1;
			end else if (c0 == 6) begin
				if (!blank) bad = 1'b1;
			end else begin
				if (!blank) fl.posbad = 1'b1;
				if (c0 == int'(DIGIT_COL) && blank) fl.blank7 = 1'b1;
				if (fl.runend) begin
					if (!blank) bad = 1'b1;
				end else if (blank) begin
					fl.runend = 1'b1;
					run_end = c0;
				end else if (v < 0) begin
					bad = 1'b1;
				end else if (((c0 - int'(DIGIT_COL)) % 2) == 0) begin
					hi = v[3:0];
				end else if (nbytes < MAX_LINE_BYTES) begin
					held[nbytes] = {hi, v[3:0]};
					nbytes++;
				end else begin
					bad = 1'b1;
				end
			end
		endfunction

		function void finish_line();
			bit ok;
			bit is_data;
			bit full;
			ok = 1'b0;
			is_data = 1'b0;
			full = (col >= int'(BAR_COL));
			if (fl.zero0 && fl.x1 && fl.blank7) begin
				ok = full && !fl.posbad;
			end else if (fl.blank0) begin
				ok = full && !fl.cmtbad && fl.bar;
			end else if (fl.zero0 && !fl.blank7) begin
				is_data = 1'b1;
				ok = !bad && fl.runend && (run_end % 2 == 1) && run_end > int'(DIGIT_COL) &&
					full && fl.bar;
				if (ok) begin
					// one byte of overlap with the previous data line is legal
					if (int'(line_addr) < prev_last) begin
						ok = 1'b0;
					end else begin
						prev_last = int'(line_addr) + nbytes - 1;
						if (prev_last >= MEM_SIZE) ok = 1'b0;
					end
				end
			end
			if (ok) begin
				if (is_data)
					for (int i = 0; i < nbytes; i++)
						add(KIND_BYTE, int'(line_addr) + i, held[i], line_no, 1'b0);
				add(KIND_ACCEPT, 0, 8'h00, line_no, 1'b0);
				any_ok = 1'b1;
				if (line_no != 16'hFFFF) line_no++;
			end else begin
				add(KIND_REJECT, 0, 8'h00, line_no, 1'b0);
				halted = 1'b1;
			end
			clear_line();
		endfunction

		function void predict_word(hol_in_t w);
			int n0;
			hol_out_t r;
			n0 = due_results.size();
			if (w.cmd == CMD_CHAR) begin
				if (!halted) begin
					if (w.ch == CHAR_LF) finish_line();
					else take_char(w.ch);
				end
			end else begin
				// close an unterminated line first
				if (!halted && col > 0) finish_line();
				clear_line();
				add(KIND_EOF, 0, 8'h00, 16'h0000, any_ok && !halted);
			end
			if (due_results.size() > n0) begin
				r = due_results.pop_back();
				r.last = 1'b1;
				due_results.push_back(r);
			end
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(hol_out_t got);
			hol_out_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result word %h", got));
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.addr !== want.addr)
				report($sformatf("addr %h, want %h", got.addr, want.addr));
			if (got.data !== want.data)
				report($sformatf("data %h, want %h", got.data, want.data));
			if (got.line_number !== want.line_number)
				report($sformatf("line_number %0d, want %0d", got.line_number,
					want.line_number));
			if (got.loaded !== want.loaded)
				report($sformatf("loaded %b, want %b", got.loaded, want.loaded));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     src_valid;
	logic     src_ready;
	hol_in_t  src_word;
	logic     res_valid;
	logic     res_ready = 1'b0;
	hol_out_t res_word;

	load_checker book = new();

	logic [7:0] text[$];
	int  mem_floor;
	bit  src_calm;
	bit  sink_calm = 1'b0;
	int  sink_hold = 0;
	int  cycles = 0;
	int  counted;
	int  pick;
	int  r;
	int  n;
	int  room;
	int  step;
	bit  lf;

	hex_object_line_loader_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_word(src_word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word(res_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int idle_len(bit calm);
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 88) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10) return CHAR_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	task automatic send_word(logic cmd, logic [7:0] ch);
		int gap;
		gap = idle_len(src_calm);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_word <= {cmd, ch};
		do @(posedge clk); while (!src_ready);
		@(negedge clk);
	endtask

	task automatic send_text(bit with_lf);
		foreach (text[i]) send_word(CMD_CHAR, text[i]);
		if (with_lf) send_word(CMD_CHAR, CHAR_LF);
	endtask

	task automatic send_eof();
		send_word(CMD_EOF, 8'($urandom_range(0, 255)));
	endtask

	task automatic pad_to(int c);
		while (text.size() < c) text.push_back(CHAR_SPACE);
	endtask

	// columns past the bar are ignored, so any byte may go there
	task automatic add_tail();
		repeat ($urandom_range(0, 3)) text.push_back(any_char());
	endtask

	task automatic build_comment();
		text.delete();
		pad_to(28);
		text.push_back(CHAR_BAR);
		add_tail();
	endtask

	task automatic build_addr_only();
		text.delete();
		text.push_back(CHAR_ZERO);
		text.push_back(CHAR_X);
		repeat (5) text.push_back(any_char());
		pad_to(28);
		text.push_back(any_char());
		add_tail();
	endtask

	task automatic build_data(int addr, int count, int fill);
		logic [11:0] a;
		logic [7:0] b;
		a = 12'(addr);
		text.delete();
		text.push_back(CHAR_ZERO);
		text.push_back(CHAR_X);
		text.push_back(hex_char(a[11:8]));
		text.push_back(hex_char(a[7:4]));
		text.push_back(hex_char(a[3:0]));
		text.push_back(CHAR_COLON);
		text.push_back(CHAR_SPACE);
		for (int i = 0; i < count; i++) begin
			b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
			text.push_back(hex_char(b[7:4]));
			text.push_back(hex_char(b[3:0]));
		end
		pad_to(28);
		text.push_back(CHAR_BAR);
		add_tail();
	endtask

	task automatic data_line(int addr, int count, int fill, bit with_lf);
		build_data(addr, count, fill);
		send_text(with_lf);
		mem_floor = addr + count - 1;
	endtask

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			res_ready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			res_ready <= 1'b1;
			sink_hold = idle_len(sink_calm);
		end
		if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && src_ready) book.predict_word(src_word);
			if (res_valid && res_ready) book.check_result(res_word);
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_word = '0;
		src_calm = 1'b0;
		mem_floor = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty file, each line kind, byte extremes, overlap, open last line
		send_eof();
		build_comment();
		text.push_back(8'hFF);
		text.push_back(8'h80);
		send_text(1'b1);
		build_addr_only();
		send_text(1'b1);
		data_line(0, 1, 0, 1'b1);
		data_line(0, MAX_LINE_BYTES, 255, 1'b1);
		send_eof();
		data_line(mem_floor, 2, -1, 1'b0);
		send_eof();

		// random: mostly well-formed data lines at rising addresses
		counted = 0;
		while (counted < 90) begin
			src_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				n = $urandom_range(1, MAX_LINE_BYTES);
				if (n > MEM_SIZE - mem_floor) n = MEM_SIZE - mem_floor;
				room = MEM_SIZE - n - mem_floor;
				r = $urandom_range(0, 99);
				if (r < 70) step = $urandom_range(0, 8);
				else if (r < 95) step = $urandom_range(0, 200);
				else step = room;
				if (step > room) step = room;
				lf = ($urandom_range(0, 9) != 0);
				data_line(mem_floor + step, n, -1, lf);
				if (!lf) send_eof();
				counted += 30;
			end else if (pick < 75) begin
				build_comment();
				send_text(1'b1);
				counted += 30;
			end else if (pick < 90) begin
				build_addr_only();
				send_text(1'b1);
				counted += 30;
			end else begin
				send_eof();
				counted += 1;
			end
		end

		// fill up to the top of memory, then overlap the very last byte
		src_calm = 1'b0;
		n = MEM_SIZE - mem_floor;
		if (n > MAX_LINE_BYTES) n = MAX_LINE_BYTES;
		data_line(MEM_SIZE - n, n, -1, 1'b1);
		data_line(MEM_SIZE - 1, 1, -1, 1'b1);

		// one bad line halts the loader
		case ($urandom_range(0, 10))
			0: text.delete();
			1: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text[8] = CHAR_SPACE;
			end
			2: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text[3] = 8'h67;
			end
			3: build_data(MEM_SIZE - 2, 1, -1);
			4: build_data(MEM_SIZE - 1, 2, -1);
			5: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text = text[0:19];
			end
			6: begin
				build_comment();
				text[$urandom_range(1, 27)] = 8'h2E;
			end
			7: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text[0] = 8'h31;
			end
			8: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text[5] = CHAR_SPACE;
			end
			9: begin
				build_addr_only();
				text[$urandom_range(7, 27)] = 8'h23;
			end
			default: begin
				build_data(MEM_SIZE - 1, 1, -1);
				text[12] = 8'h37;
			end
		endcase
		send_text(1'b1);

		// halted: lines drop silently, end of file reports not loaded
		build_comment();
		send_text(1'b1);
		send_eof();
		send_word(CMD_CHAR, CHAR_ZERO);
		send_eof();

		src_valid <= 1'b0;
		while (book.due_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (book.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/hol_pkg.sv
rtl/hol_ram.sv
rtl/hex_object_line_loader_core.sv
rtl/hol_chk.sv
sim/hex_object_line_loader_core_tb.sv
